// ----- rtl/tst_pkg.sv -----
`default_nettype none
package tst_pkg;

  localparam int ENTRIES = 5;
  localparam int CNT_W   = $clog2(ENTRIES);
  localparam int CMP_W   = (CNT_W > 3) ? CNT_W : 3;

  localparam logic [31:0] CEILING_RESET = 32'd10000000;

  typedef enum logic [2:0] {
    FN_QUALIFY = 3'd0,
    FN_ENTER   = 3'd1,
    FN_SORT    = 3'd2,
    FN_READ    = 3'd3,
    FN_WRITE   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WB,
    ST_SORT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] score;
    logic [31:0] tag;
  } entry_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] score;
    logic [31:0] name_tag;
    logic [2:0]  slot;
  } in_t;

  typedef struct packed {
    logic [2:0]  rank;
    logic        entered;
    logic [2:0]  entered_slot;
    logic [31:0] slot_score;
    logic [31:0] slot_tag;
  } out_t;

  typedef struct packed {
    logic shift_en;
    logic sort_en;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/tst_cell.sv -----
`default_nettype none
module tst_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  tst_pkg::cell_ctl_t ctl,
  input  logic              lead_en,
  input  tst_pkg::entry_t   right_in,
  input  tst_pkg::entry_t   left_in,
  input  logic              left_swap,
  output tst_pkg::entry_t   ent,
  output logic              swap_right
);
  import tst_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // lead of a pair swaps when the right entry is strictly larger
  assign swap_right = ctl.sort_en && lead_en && (ent_r.score < right_in.score);

  always_comb begin
    priority if (ctl.shift_en) begin
      ent_nxt = right_in;
    end else if (swap_right) begin
      ent_nxt = right_in;
    end else if (ctl.sort_en && left_swap) begin
      ent_nxt = left_in;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

// ----- rtl/top_score_table_core.sv -----
`default_nettype none
// score table of ENTRIES entries, each a 32-bit score and a 32-bit tag,
// held in a row of cells that either rotate toward cell 0 or compare and
// exchange with their neighbor.
// input channel: in_valid/in_ready, one beat per operation (in_data.func
// selects qualify, enter, sort, read or write). every beat gives exactly
// one result beat on out_valid/out_ready.
// qualify, read and write: one rotation of the row, with the entry
// passing cell 0 checked or replaced, then a step to the output
// register. enter: one rotation to find the slot and, when a slot is
// found, a second rotation to write it. sort: ENTRIES rounds of odd-even
// neighbor exchange. unused selector codes go straight to the output
// register without touching the table. one operation is in work at a
// time; the next beat is taken once the finished result sits in the
// output register, even if the receiver has not yet taken it.
// when the receiver stalls with a result still held, the next result waits
// in the sequencer and no further beat is taken.
// cfg_we/cfg_wdata write the enter ceiling at once; reset sets it to
// 10000000 and clears all entries to zero score and zero tag.
module top_score_table_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tst_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tst_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata
);
  import tst_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  in_t              op_r;
  out_t             res_r, res_nxt;
  logic [31:0]      thr_r, thr_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [31:0]      ceiling_r;
  logic             out_valid_r;
  out_t             out_data_r;

  cell_ctl_t        ctl;
  entry_t           feed;
  entry_t           head;
  entry_t           ent_vec [ENTRIES];
  logic [ENTRIES-1:0] swap_vec;
  logic [ENTRIES-1:0] lead_vec;
  logic [ENTRIES-1:0] ordered_vec;

  logic in_fire;
  logic last_cnt;
  logic out_free;
  logic slot_hit;
  logic pos_hit;
  logic cand;

  assign head     = ent_vec[0];
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign last_cnt = (cnt_r == CNT_W'(ENTRIES - 1));
  assign out_free = !out_valid_r || out_ready;
  assign slot_hit = (CMP_W'(cnt_r) == CMP_W'(op_r.slot));
  assign pos_hit  = (cnt_r == pos_r);
  assign cand     = (head.score < thr_r);

  // cell row
  genvar k;
  generate
    for (k = 0; k < ENTRIES; k++) begin : g_cell
      entry_t right_w;
      entry_t left_w;
      logic   lswap_w;
      if (k == ENTRIES - 1) begin : g_tail
        assign right_w     = feed;
        assign lead_vec[k] = 1'b0;
      end else begin : g_mid
        assign right_w     = ent_vec[k+1];
        assign lead_vec[k] = ctl.sort_en && (1'(k % 2) == cnt_r[0]);
      end
      if (k == 0) begin : g_first
        assign left_w  = ent_vec[0];
        assign lswap_w = 1'b0;
        assign ordered_vec[k] = 1'b1;
      end else begin : g_rest
        assign left_w  = ent_vec[k-1];
        assign lswap_w = swap_vec[k-1];
        assign ordered_vec[k] = (ent_vec[k-1].score >= ent_vec[k].score);
      end
      tst_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .lead_en    (lead_vec[k]),
        .right_in   (right_w),
        .left_in    (left_w),
        .left_swap  (lswap_w),
        .ent        (ent_vec[k]),
        .swap_right (swap_vec[k])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.func)
            FN_QUALIFY, FN_ENTER, FN_READ, FN_WRITE: state_nxt = ST_SCAN;
            FN_SORT: state_nxt = ST_SORT;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (last_cnt) begin
          if ((op_r.func == FN_ENTER) && (found_r || cand)) begin
            state_nxt = ST_WB;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WB: begin
        if (last_cnt) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SORT: begin
        if (last_cnt) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // row control and ring feed
  always_comb begin
    ctl.shift_en = 1'b0;
    ctl.sort_en  = 1'b0;
    feed         = head;
    unique case (state_r)
      ST_SCAN: begin
        ctl.shift_en = 1'b1;
        if ((op_r.func == FN_WRITE) && slot_hit) begin
          feed.score = op_r.score;
          feed.tag   = op_r.name_tag;
        end
      end
      ST_WB: begin
        ctl.shift_en = 1'b1;
        if (pos_hit) begin
          feed.score = op_r.score;
          feed.tag   = op_r.name_tag;
        end
      end
      ST_SORT: ctl.sort_en = 1'b1;
      ST_IDLE, ST_DONE: ;
      default: ;
    endcase
  end

  // scan bookkeeping
  always_comb begin
    res_nxt   = res_r;
    thr_nxt   = thr_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    if (in_fire) begin
      res_nxt   = '0;
      thr_nxt   = ceiling_r;
      found_nxt = 1'b0;
      pos_nxt   = '0;
      cnt_nxt   = '0;
    end else if ((state_r == ST_SCAN) || (state_r == ST_WB) || (state_r == ST_SORT)) begin
      cnt_nxt = last_cnt ? '0 : cnt_r + 1'b1;
      if (state_r == ST_SCAN) begin
        unique case (op_r.func)
          FN_QUALIFY: begin
            if (!found_r && (head.score < op_r.score)) begin
              found_nxt    = 1'b1;
              res_nxt.rank = 3'({1'b0, cnt_r} + 1'b1);
            end
          end
          FN_ENTER: begin
            if (cand) begin
              found_nxt            = 1'b1;
              thr_nxt              = head.score;
              pos_nxt              = cnt_r;
              res_nxt.entered      = 1'b1;
              res_nxt.entered_slot = 3'(cnt_r);
            end
          end
          FN_READ: begin
            if (slot_hit) begin
              res_nxt.slot_score = head.score;
              res_nxt.slot_tag   = head.tag;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      ceiling_r   <= CEILING_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      if (cfg_we) begin
        ceiling_r <= cfg_wdata;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_data;
    end
    res_r <= res_nxt;
    thr_r <= thr_nxt;
    pos_r <= pos_nxt;
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_wb_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> (found_r && (op_r.func == FN_ENTER)))
    else $error("write-back pass without a found slot");

  a_sorted_after_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SORT) && last_cnt |=> (&ordered_vec))
    else $error("table not in descending order after sort");

  a_single_field: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && res_r.entered |-> (res_r.rank == 3'd0))
    else $error("enter result carries a rank");

  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("accepted beat did not start work");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready && (state_r == ST_DONE) |=> (state_r == ST_DONE))
    else $error("result left the sequencer while output held");

endmodule
`default_nettype wire

// ----- tb/sv/top_score_table_core_tb.sv -----
`default_nettype none
module top_score_table_core_tb;
  import tst_pkg::*;

  localparam int PERIOD = 20;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_BEATS = 280;
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 4;
  localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FN_SPARE_LAST = 3'd7;
  localparam logic [31:0] SMALL_CEILING = 32'd16;

  class score_board;
    logic [31:0] ceiling;
    logic [31:0] scores [ENTRIES];
    logic [31:0] tags [ENTRIES];
    out_t expected[$];
    int fails;
    int op_count [8];
    int enter_hits;

    function new();
      ceiling = CEILING_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        scores[i] = '0;
        tags[i] = '0;
      end
      fails = 0;
      enter_hits = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function out_t apply_op(in_t b);
      out_t r;
      logic [31:0] thr, ks, kt;
      int pos, j;
      bit found;
      r = '0;
      case (b.func)
        FN_QUALIFY: begin
          if (b.score != '0) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (r.rank == '0 && scores[i] < b.score) r.rank = 3'(i + 1);
            end
          end
        end
        FN_ENTER: begin
          thr = ceiling;
          found = 1'b0;
          pos = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (scores[i] < thr) begin
              found = 1'b1;
              pos = i;
              thr = scores[i];
            end
          end
          if (found) begin
            scores[pos] = b.score;
            tags[pos] = b.name_tag;
            r.entered = 1'b1;
            r.entered_slot = 3'(pos);
          end
        end
        FN_SORT: begin
          for (int i = 1; i < ENTRIES; i++) begin
            ks = scores[i];
            kt = tags[i];
            j = i;
            while (j > 0 && scores[j - 1] < ks) begin
              scores[j] = scores[j - 1];
              tags[j] = tags[j - 1];
              j--;
            end
            scores[j] = ks;
            tags[j] = kt;
          end
        end
        FN_READ: begin
          if (b.slot < ENTRIES) begin
            r.slot_score = scores[b.slot];
            r.slot_tag = tags[b.slot];
          end
        end
        FN_WRITE: begin
          if (b.slot < ENTRIES) begin
            scores[b.slot] = b.score;
            tags[b.slot] = b.name_tag;
          end
        end
        default: begin
        end
      endcase
      return r;
    endfunction

    task note_beat(in_t b);
      out_t r;
      r = apply_op(b);
      op_count[b.func]++;
      if (r.entered) enter_hits++;
      expected.push_back(r);
    endtask

    task report(string msg);
      fails++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_beat(out_t got);
      out_t want;
      if (expected.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      want = expected.pop_front();
      if (got.rank !== want.rank)
        report($sformatf("rank got %0d want %0d", got.rank, want.rank));
      if (got.entered !== want.entered)
        report($sformatf("entered got %0d want %0d", got.entered, want.entered));
      if (got.entered_slot !== want.entered_slot)
        report($sformatf("entered_slot got %0d want %0d", got.entered_slot,
                         want.entered_slot));
      if (got.slot_score !== want.slot_score)
        report($sformatf("slot_score got %h want %h", got.slot_score, want.slot_score));
      if (got.slot_tag !== want.slot_tag)
        report($sformatf("slot_tag got %h want %h", got.slot_tag, want.slot_tag));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  score_board sb;
  bit tx_gaps;
  bit rx_gaps;
  int tx_count;
  int rx_cyc;
  int rx_wait;
  int hold_seq;
  int hold_seen;
  int ceiling_loads;

  top_score_table_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #(PERIOD / 2) clk = ~clk;

  initial begin
    #(PERIOD * LIMIT_CYCLES);
    $display("timeout with beats still outstanding");
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: check, then decide ready for the next cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_beat(out_data);
      rx_cyc++;
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        rx_wait = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else if (rx_gaps && (rx_cyc % 128) >= 32 && $urandom_range(4, 0) == 0) begin
        rx_wait = $urandom_range(2, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_t mk(logic [2:0] f, logic [31:0] s, logic [31:0] t,
                             logic [2:0] sl);
    in_t b;
    b.func = f;
    b.score = s;
    b.name_tag = t;
    b.slot = sl;
    return b;
  endfunction

  function automatic logic [31:0] pick_score();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      2, 3: return 32'($urandom_range(30, 1));
      4: return sb.ceiling + 32'($urandom_range(4, 0)) - 32'd2;
      5, 6: return sb.scores[$urandom_range(ENTRIES - 1, 0)] + 32'($urandom_range(2, 0))
                   - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t pick_beat();
    in_t b;
    int n;
    n = $urandom_range(99, 0);
    if (n < 25) b.func = FN_QUALIFY;
    else if (n < 50) b.func = FN_ENTER;
    else if (n < 60) b.func = FN_SORT;
    else if (n < 78) b.func = FN_READ;
    else if (n < 95) b.func = FN_WRITE;
    else b.func = 3'($urandom_range(FN_SPARE_LAST, FN_SPARE_FIRST));
    b.score = pick_score();
    b.name_tag = $urandom;
    if ($urandom_range(6, 0) == 0) b.slot = 3'($urandom_range(7, ENTRIES));
    else b.slot = 3'($urandom_range(ENTRIES - 1, 0));
    return b;
  endfunction

  task automatic send_beat(in_t b);
    if (tx_gaps && (tx_count % 64) >= 16 && $urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_beat(b);
    tx_count++;
  endtask

  task automatic run_phase(int beats);
    repeat (beats) send_beat(pick_beat());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_ceiling(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.ceiling = v;
    ceiling_loads++;
  endtask

  task automatic directed_beats();
    send_beat(mk(FN_READ, '0, '0, 3'd0));
    send_beat(mk(FN_QUALIFY, '0, '0, 3'd0));
    send_beat(mk(FN_QUALIFY, 32'd1, '0, 3'd0));
    send_beat(mk(FN_QUALIFY, '1, '1, 3'd7));
    send_beat(mk(FN_ENTER, '1, 32'h0000_00A1, 3'd0));
    send_beat(mk(FN_ENTER, CEILING_RESET - 32'd1, 32'h0000_00B2, 3'd0));
    send_beat(mk(FN_ENTER, '0, 32'h0000_00C3, 3'd0));
    send_beat(mk(FN_ENTER, 32'd5, '1, 3'd0));
    send_beat(mk(FN_WRITE, CEILING_RESET, '1, 3'd3));
    send_beat(mk(FN_WRITE, '1, 32'h0000_0005, 3'(ENTRIES - 1)));
    send_beat(mk(FN_WRITE, 32'd1, 32'd1, 3'd7));
    send_beat(mk(FN_WRITE, 32'd2, 32'd2, 3'(ENTRIES)));
    send_beat(mk(FN_READ, '1, '1, 3'd6));
    send_beat(mk(FN_SORT, '0, '0, 3'd0));
    for (int i = 0; i < ENTRIES; i++) send_beat(mk(FN_READ, '0, '0, 3'(i)));
    send_beat(mk(FN_QUALIFY, 32'd6, '0, 3'd0));
    send_beat(mk(FN_QUALIFY, 32'd5, '0, 3'd0));
    send_beat(mk(FN_ENTER, '0, '0, 3'd0));
    for (logic [3:0] f = FN_SPARE_FIRST; f <= FN_SPARE_LAST; f++)
      send_beat(mk(f[2:0], '1, '1, 3'd7));
  endtask

  initial begin
    sb = new();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    tx_count = 0;
    rx_cyc = 0;
    rx_wait = 0;
    hold_seq = 0;
    hold_seen = 0;
    ceiling_loads = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_beats();
    run_phase(PHASE_BEATS);
    drain();

    load_ceiling('0);
    run_phase(PHASE_BEATS);
    drain();

    load_ceiling('1);
    hold_seq <= hold_seq + 1;
    run_phase(PHASE_BEATS);
    drain();

    load_ceiling($urandom);
    hold_seq <= hold_seq + 1;
    run_phase(PHASE_BEATS);
    drain();

    load_ceiling(SMALL_CEILING);
    run_phase(PHASE_BEATS);
    drain();

    // last stretch runs at full rate on both sides
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    load_ceiling(CEILING_RESET);
    run_phase(PHASE_BEATS);
    drain();

    $display("%0d beats over %0d ceiling loads: qualify %0d, enter %0d (%0d written)",
             tx_count, ceiling_loads, sb.op_count[FN_QUALIFY], sb.op_count[FN_ENTER],
             sb.enter_hits);
    $display("sort %0d, read %0d, write %0d, spare codes %0d, mismatches %0d",
             sb.op_count[FN_SORT], sb.op_count[FN_READ], sb.op_count[FN_WRITE],
             sb.op_count[FN_SPARE_FIRST] + sb.op_count[FN_SPARE_LAST - 3'd1]
             + sb.op_count[FN_SPARE_LAST], sb.fails);
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
